>>> src/mhpq_pkg.sv
// Package of shared types and codes for the min-heap priority queue.
package mhpq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_ERASE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [7:0]  handle;
        logic [63:0] key;
    } mhpq_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        min_valid;
        logic [63:0] min_key;
        logic [7:0]  min_handle;
        logic [8:0]  entry_count;
    } mhpq_out_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture the input beat
        logic rd_a;        // select the smaller valid child into the compared entry
        logic rd_last;     // read last entry into the working entry
        logic rd_par;      // read parent of pos
        logic rd_kids;     // read both children of pos
        logic wr_new;      // write working entry at pos
        logic wr_other;    // write the compared entry at pos
        logic move_par;    // pos <= parent
        logic move_kid;    // pos <= chosen child
        logic ins_commit;  // count up, mark handle present
        logic era_commit;  // count down, clear handle present
        logic rd_root;     // read the root
        logic finish;      // load the result register
        logic [1:0] status;
    } mhpq_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic operation;
        logic full;
        logic present;
        logic empty;
        logic pos_zero;
        logic pos_is_last;
        logic par_greater;  // working key < parent key
        logic has_kid;
        logic kid_less;     // chosen child key < working key
    } mhpq_stat_t;

endpackage

>>> src/min_heap_priority_queue_core.sv
// Top level of the bounded binary min-heap priority queue with erase by handle.
// Beats are handled one at a time: a new beat is taken only once the previous one has
// finished its sift over the single-write entry memory and its result can be taken.
// Reset clears the handle table's present bits and the entry count at once, so no
// clearing pass is needed; the entry memories stay undefined until written.
module min_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mhpq_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output mhpq_out_t out_data
);
    mhpq_cmd_t  cmd;
    mhpq_stat_t stat;

    // The controller walks the tree; the datapath holds the memories and compares keys.
    mhpq_control u_control
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mhpq_datapath #(.CAPACITY(CAPACITY)) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_data)
    );

endmodule

>>> src/mhpq_datapath.sv
// Datapath of the min-heap: entry memories, handle table, comparators and result register.
module mhpq_datapath
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  mhpq_in_t   in_data,
    input  mhpq_cmd_t  cmd,
    output mhpq_stat_t stat,
    output mhpq_out_t  result
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [63:0] key_mem [CAPACITY];
    logic [7:0]  hnd_mem [CAPACITY];
    logic [AW-1:0] pos_mem [256];
    logic [255:0] present_reg;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] pos_reg;
    logic          op_reg;
    logic [7:0]    h_reg;
    logic [63:0]   wk_reg;   // working entry
    logic [7:0]    wh_reg;
    logic [63:0]   ok_reg;   // compared entry (parent or chosen child)
    logic [7:0]    oh_reg;
    logic [AW-1:0] opos_reg;
    logic [63:0]   lk_reg, rk_reg;
    logic [7:0]    lh_reg, rh_reg;
    logic          rvalid_reg;
    logic [AW-1:0] hpos_reg;
    mhpq_out_t     result_reg;

    logic [CW:0]   lpos_w, rpos_w;
    logic [AW-1:0] par_w, last_w;
    logic          pick_r;

    assign par_w  = AW'((pos_reg - AW'(1)) >> 1);
    assign lpos_w = (CW+1)'({pos_reg, 1'b1});
    assign rpos_w = lpos_w + (CW+1)'(1);
    // Read after the count has already been decremented, so the count is the last position.
    assign last_w = AW'(count_reg);
    assign pick_r = rvalid_reg && ($signed(rk_reg) < $signed(lk_reg));

    // Memory accesses: one write and up to two reads per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            hpos_reg <= pos_mem[in_data.handle];
        if (cmd.wr_new)
        begin
            key_mem[pos_reg] <= wk_reg;
            hnd_mem[pos_reg] <= wh_reg;
            pos_mem[wh_reg]  <= pos_reg;
        end
        else if (cmd.wr_other)
        begin
            key_mem[pos_reg] <= ok_reg;
            hnd_mem[pos_reg] <= oh_reg;
            pos_mem[oh_reg]  <= pos_reg;
        end
        if (cmd.rd_last)
        begin
            wk_reg <= key_mem[last_w];
            wh_reg <= hnd_mem[last_w];
        end
        else if (cmd.load)
        begin
            wk_reg <= in_data.key;
            wh_reg <= in_data.handle;
        end
        if (cmd.rd_par)
        begin
            ok_reg   <= key_mem[par_w];
            oh_reg   <= hnd_mem[par_w];
            opos_reg <= par_w;
        end
        else if (cmd.rd_a)
        begin
            ok_reg <= pick_r ? rk_reg : lk_reg;
            oh_reg <= pick_r ? rh_reg : lh_reg;
            opos_reg <= pick_r ? AW'(rpos_w) : AW'(lpos_w);
        end
        if (cmd.rd_kids)
        begin
            lk_reg <= key_mem[AW'(lpos_w)];
            lh_reg <= hnd_mem[AW'(lpos_w)];
            rk_reg <= key_mem[AW'(rpos_w)];
            rh_reg <= hnd_mem[AW'(rpos_w)];
            rvalid_reg <= (rpos_w < (CW+1)'(count_reg));
        end
        if (cmd.rd_root)
        begin
            result_reg.min_key    <= key_mem[0];
            result_reg.min_handle <= hnd_mem[0];
        end
        if (cmd.finish)
        begin
            result_reg.status      <= cmd.status;
            result_reg.min_valid   <= (count_reg != '0);
            result_reg.entry_count <= 9'(count_reg);
            if (count_reg == '0)
            begin
                result_reg.min_key    <= '0;
                result_reg.min_handle <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            count_reg   <= '0;
            pos_reg     <= '0;
            op_reg      <= 1'b0;
            h_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg <= in_data.operation;
                h_reg  <= in_data.handle;
                if (in_data.operation == OP_INSERT)
                    pos_reg <= AW'(count_reg);
            end
            if (cmd.rd_last)
                pos_reg <= hpos_reg;
            if (cmd.ins_commit)
            begin
                count_reg <= count_reg + CW'(1);
                present_reg[h_reg] <= 1'b1;
            end
            if (cmd.era_commit)
            begin
                count_reg <= count_reg - CW'(1);
                present_reg[h_reg] <= 1'b0;
            end
            if (cmd.move_par || cmd.move_kid)
                pos_reg <= opos_reg;
        end
    end

    always_comb
    begin
        stat.operation   = op_reg;
        stat.full        = (count_reg >= CW'(CAPACITY));
        stat.present     = present_reg[h_reg];
        stat.empty       = (count_reg == '0);
        stat.pos_zero    = (pos_reg == '0);
        stat.pos_is_last = (CW'(hpos_reg) == count_reg);
        stat.par_greater = ($signed(wk_reg) < $signed(ok_reg));
        stat.has_kid     = (lpos_w < (CW+1)'(count_reg));
        stat.kid_less    = ($signed(ok_reg) < $signed(wk_reg));
    end

    assign result = result_reg;

endmodule

>>> src/mhpq_control.sv
// Controller state machine that sequences inserts, erases and sifts.
module mhpq_control
    import mhpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  mhpq_stat_t stat,
    output mhpq_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_UPRD   = 4'd2;
    localparam logic [3:0] S_UPCMP  = 4'd3;
    localparam logic [3:0] S_ERLST  = 4'd4;
    localparam logic [3:0] S_ERDEC  = 4'd5;
    localparam logic [3:0] S_DNRD   = 4'd6;
    localparam logic [3:0] S_DNSEL  = 4'd7;
    localparam logic [3:0] S_DNCMP  = 4'd8;
    localparam logic [3:0] S_ROOT   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_ERPAR  = 4'd11;
    localparam logic [3:0] S_UPW    = 4'd12;
    localparam logic [3:0] S_ERCMP  = 4'd13;
    localparam logic [3:0] S_UPW_DN = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.status     = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                status_next = ST_OK;
                if (stat.operation == OP_INSERT)
                begin
                    if (stat.full)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_ROOT;
                    end
                    else if (stat.present)
                    begin
                        status_next = ST_PRESENT;
                        state_next  = S_ROOT;
                    end
                    else
                    begin
                        cmd.wr_new     = 1'b1;
                        cmd.ins_commit = 1'b1;
                        state_next     = S_UPRD;
                    end
                end
                else if (!stat.present || stat.empty)
                begin
                    status_next = ST_ABSENT;
                    state_next  = S_ROOT;
                end
                else
                begin
                    state_next = S_ERLST;
                end
            end
            S_UPRD:
            begin
                if (stat.pos_zero)
                    state_next = S_ROOT;
                else
                begin
                    cmd.rd_par = 1'b1;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (stat.par_greater)
                begin
                    cmd.wr_other = 1'b1;
                    cmd.move_par = 1'b1;
                    state_next   = S_UPW;
                end
                else
                    state_next = S_ROOT;
            end
            S_UPW:
            begin
                cmd.wr_new = 1'b1;
                state_next = S_UPRD;
            end
            S_ERLST:
            begin
                // hpos_reg holds the position; pos_is_last compares it with count-1 after decrement.
                cmd.era_commit = 1'b1;
                state_next     = S_ERDEC;
            end
            S_ERDEC:
            begin
                if (stat.pos_is_last)
                    state_next = S_ROOT;
                else
                begin
                    cmd.rd_last = 1'b1;
                    state_next  = S_ERPAR;
                end
            end
            S_ERPAR:
            begin
                cmd.wr_new = 1'b1;
                if (stat.pos_zero)
                    state_next = S_DNRD;
                else
                begin
                    cmd.rd_par = 1'b1;
                    state_next = S_ERCMP;
                end
            end
            S_ERCMP:
            begin
                // The moved entry climbs if it is below its parent and sinks otherwise.
                if (stat.par_greater)
                begin
                    cmd.wr_other = 1'b1;
                    cmd.move_par = 1'b1;
                    state_next   = S_UPW;
                end
                else
                    state_next = S_DNRD;
            end
            S_DNRD:
            begin
                if (stat.has_kid)
                begin
                    cmd.rd_kids = 1'b1;
                    state_next  = S_DNSEL;
                end
                else
                    state_next = S_ROOT;
            end
            S_DNSEL:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                if (stat.kid_less)
                begin
                    cmd.wr_other = 1'b1;
                    cmd.move_kid = 1'b1;
                    state_next   = S_UPW_DN;
                end
                else
                    state_next = S_ROOT;
            end
            S_UPW_DN:
            begin
                cmd.wr_new = 1'b1;
                state_next = S_DNRD;
            end
            S_ROOT:
            begin
                cmd.rd_root = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
